@@ hw/rtl/oeu_pkg.sv @@
// oeu_pkg: shared types and constants for the oregonator euler integrator
// no dependencies; used by oeu_regs, oeu_mul and the top level
package oeu_pkg;

  localparam int STATE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int GAIN_BITS      = 16;
  localparam int OUT_BITS       = 32;
  localparam int COUNT_BITS     = 8;
  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 4;

  localparam logic [GAIN_BITS-1:0] RST_STEP_SIZE = 16'd655;
  localparam logic [GAIN_BITS-1:0] RST_EPSILON   = 16'd32768;
  localparam logic [GAIN_BITS-1:0] RST_MU        = 16'd32768;
  localparam logic [GAIN_BITS-1:0] RST_Q         = 16'd32768;

  typedef enum logic [1:0] {
    REG_STEP_SIZE = 2'd0,
    REG_EPSILON   = 2'd1,
    REG_MU        = 2'd2,
    REG_Q         = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_BITS-1:0] step_size;
    logic [GAIN_BITS-1:0] epsilon_gain;
    logic [GAIN_BITS-1:0] mu_gain;
    logic [GAIN_BITS-1:0] q_gain;
  } cfg_t;

endpackage

@@ hw/rtl/oeu_regs.sv @@
// oeu_regs: apb configuration registers for the model gains
// depends on oeu_pkg
module oeu_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [oeu_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [oeu_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [oeu_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                             pready,
  output oeu_pkg::cfg_t                    cfg_o
);
  import oeu_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size    <= RST_STEP_SIZE;
      cfg_q.epsilon_gain <= RST_EPSILON;
      cfg_q.mu_gain      <= RST_MU;
      cfg_q.q_gain       <= RST_Q;
    end else if (wr_en) begin
      unique case (idx)
        REG_STEP_SIZE: cfg_q.step_size    <= pwdata[GAIN_BITS-1:0];
        REG_EPSILON:   cfg_q.epsilon_gain <= pwdata[GAIN_BITS-1:0];
        REG_MU:        cfg_q.mu_gain      <= pwdata[GAIN_BITS-1:0];
        REG_Q:         cfg_q.q_gain       <= pwdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEP_SIZE: prdata = APB_DATA_BITS'(cfg_q.step_size);
      REG_EPSILON:   prdata = APB_DATA_BITS'(cfg_q.epsilon_gain);
      REG_MU:        prdata = APB_DATA_BITS'(cfg_q.mu_gain);
      REG_Q:         prdata = APB_DATA_BITS'(cfg_q.q_gain);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/oeu_mul.sv @@
// oeu_mul: shared sign-magnitude multiplier, 16 bits of the second operand per cycle
// gain mode: a * gain >> 16; state mode: a * b >> FRAC_BITS, saturated
// depends on oeu_pkg
module oeu_mul #(
  parameter int STATE_BITS = oeu_pkg::STATE_BITS_DEF,
  parameter int FRAC_BITS  = oeu_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         gain_mode_i,
  input  logic signed [STATE_BITS-1:0] a_i,
  input  logic signed [STATE_BITS-1:0] b_i,
  output logic                         done_o,
  output logic signed [STATE_BITS-1:0] result_o
);
  import oeu_pkg::*;

  localparam int NCH   = (STATE_BITS + GAIN_BITS - 1) / GAIN_BITS;
  localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int BW    = NCH * GAIN_BITS;
  localparam int ACC_W = STATE_BITS + BW;
  localparam int PW    = STATE_BITS + GAIN_BITS;

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_FIN
  } mstate_e;

  mstate_e               st_q;
  logic [STATE_BITS-1:0] ma_q;
  logic [BW-1:0]         mb_q;
  logic [CW-1:0]         cnt_q;
  logic [ACC_W-1:0]      acc_q;
  logic                  neg_q;
  logic                  gain_q;

  logic [STATE_BITS-1:0] ma;
  logic [STATE_BITS-1:0] mb;
  logic [GAIN_BITS-1:0]  chunk;
  logic [PW-1:0]         prod;
  logic [ACC_W-1:0]      shifted;
  logic [ACC_W-1:0]      limit;
  logic [ACC_W-1:0]      clamped;
  logic [STATE_BITS-1:0] mag_r;

  assign ma    = a_i[STATE_BITS-1] ? (~a_i + 1'b1) : a_i;
  assign mb    = b_i[STATE_BITS-1] ? (~b_i + 1'b1) : b_i;
  assign chunk = mb_q[{cnt_q, 4'b0000} +: GAIN_BITS];
  assign prod  = PW'(ma_q) * PW'(chunk);

  // result clamp; gain products never reach the limit
  always_comb begin
    shifted = gain_q ? (acc_q >> GAIN_BITS) : (acc_q >> FRAC_BITS);
    limit   = neg_q ? (ACC_W'(1) << (STATE_BITS - 1))
                    : ((ACC_W'(1) << (STATE_BITS - 1)) - ACC_W'(1));
    clamped = (shifted > limit) ? limit : shifted;
    mag_r   = clamped[STATE_BITS-1:0];
  end

  assign result_o = neg_q ? (~mag_r + 1'b1) : mag_r;
  assign done_o   = (st_q == M_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      ma_q   <= '0;
      mb_q   <= '0;
      cnt_q  <= '0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      gain_q <= 1'b0;
    end else begin
      unique case (st_q)
        M_IDLE: begin
          if (start_i) begin
            ma_q   <= ma;
            gain_q <= gain_mode_i;
            acc_q  <= '0;
            st_q   <= M_RUN;
            if (gain_mode_i) begin
              mb_q  <= BW'(b_i[GAIN_BITS-1:0]);
              neg_q <= a_i[STATE_BITS-1];
              cnt_q <= '0;
            end else begin
              mb_q  <= BW'(mb);
              neg_q <= a_i[STATE_BITS-1] ^ b_i[STATE_BITS-1];
              cnt_q <= CW'(NCH - 1);
            end
          end
        end
        M_RUN: begin
          // most significant chunk first, shift and add
          acc_q <= (acc_q << GAIN_BITS) + ACC_W'(prod);
          if (cnt_q == '0) begin
            st_q <= M_FIN;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        M_FIN: begin
          st_q <= M_IDLE;
        end
        default: st_q <= M_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/oregonator_euler_integrator_top.sv @@
// oregonator euler integrator: forward euler on x, y, z over a shared multiplier
// each step is eight multiplies (six by gains, two state products), all through
//   the one multiplier in oeu_mul
// the input is not ready while steps run or while a finished result waits for
//   the output register
// reset: x, y, z go to 0.5, registers to their defaults, no output pending
module oregonator_euler_integrator_top #(
  parameter int STATE_BITS = oeu_pkg::STATE_BITS_DEF,
  parameter int FRAC_BITS  = oeu_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [oeu_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [oeu_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [oeu_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] step_count
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [95:0]                       m_axis_tdata   // [31:0] x, [63:32] y, [95:64] z
);
  import oeu_pkg::*;

  localparam int SB = STATE_BITS;
  localparam logic signed [63:0] SMAX_L   = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [63:0] ONE_RAW  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF_RAW = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE_L    = (ONE_RAW > SMAX_L) ? SMAX_L : ONE_RAW;
  localparam logic signed [63:0] HALF_L   = (HALF_RAW > SMAX_L) ? SMAX_L : HALF_RAW;
  localparam logic signed [SB-1:0] ONE    = ONE_L[SB-1:0];
  localparam logic signed [SB-1:0] HALF   = HALF_L[SB-1:0];
  localparam logic signed [SB+1:0] SMAX_W = {3'b000, {(SB - 1){1'b1}}};
  localparam logic signed [SB+1:0] SMIN_W = {3'b111, {(SB - 1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QY,
    ST_XY,
    ST_XX,
    ST_DX,
    ST_DY,
    ST_UX,
    ST_UY,
    ST_UZ,
    ST_DONE
  } state_e;

  function automatic logic signed [SB-1:0] sat_w(input logic signed [SB+1:0] v);
    if (v > SMAX_W) return SMAX_W[SB-1:0];
    if (v < SMIN_W) return SMIN_W[SB-1:0];
    return v[SB-1:0];
  endfunction

  function automatic logic signed [SB-1:0] add_s(input logic signed [SB-1:0] a,
                                                 input logic signed [SB-1:0] b);
    return sat_w((SB + 2)'(a) + (SB + 2)'(b));
  endfunction

  function automatic logic signed [SB-1:0] sub_s(input logic signed [SB-1:0] a,
                                                 input logic signed [SB-1:0] b);
    return sat_w((SB + 2)'(a) - (SB + 2)'(b));
  endfunction

  function automatic logic [OUT_BITS-1:0] to_out(input logic signed [SB-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[OUT_BITS-1:0];
  endfunction

  cfg_t cfg;

  oeu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e                st_q;
  logic                  issued_q;
  logic [COUNT_BITS-1:0] n_q;
  logic signed [SB-1:0]  x_q, y_q, z_q;
  logic signed [SB-1:0]  qy_q, xy_q, xx_q, dx_q, dy_q, dz_q, ty_q;
  logic                  out_valid_q;
  logic [95:0]           out_data_q;

  logic                  mul_state;
  logic                  mul_start;
  logic                  mul_gain;
  logic signed [SB-1:0]  mul_a, mul_b;
  logic                  mul_done;
  logic signed [SB-1:0]  mul_r;
  logic signed [SB-1:0]  tx;
  logic                  in_acc;
  logic                  out_load;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  // the output register takes a new word once the previous one has gone
  assign out_load      = (st_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  assign tx = add_s(sub_s(qy_q, xy_q), xx_q);

  always_comb begin
    mul_state = 1'b1;
    mul_gain  = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (st_q)
      ST_QY: begin
        mul_a = y_q;
        mul_b = SB'(cfg.q_gain);
      end
      ST_XY: begin
        mul_gain = 1'b0;
        mul_a    = x_q;
        mul_b    = y_q;
      end
      ST_XX: begin
        mul_gain = 1'b0;
        mul_a    = x_q;
        mul_b    = sub_s(ONE, x_q);
      end
      ST_DX: begin
        mul_a = tx;
        mul_b = SB'(cfg.epsilon_gain);
      end
      ST_DY: begin
        mul_a = ty_q;
        mul_b = SB'(cfg.mu_gain);
      end
      ST_UX: begin
        mul_a = dx_q;
        mul_b = SB'(cfg.step_size);
      end
      ST_UY: begin
        mul_a = dy_q;
        mul_b = SB'(cfg.step_size);
      end
      ST_UZ: begin
        mul_a = dz_q;
        mul_b = SB'(cfg.step_size);
      end
      default: mul_state = 1'b0;
    endcase
    mul_start = mul_state && !issued_q;
  end

  oeu_mul #(
    .STATE_BITS (STATE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (mul_start),
    .gain_mode_i (mul_gain),
    .a_i         (mul_a),
    .b_i         (mul_b),
    .done_o      (mul_done),
    .result_o    (mul_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      issued_q    <= 1'b0;
      n_q         <= '0;
      x_q         <= HALF;
      y_q         <= HALF;
      z_q         <= HALF;
      qy_q        <= '0;
      xy_q        <= '0;
      xx_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      dz_q        <= '0;
      ty_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (mul_start) begin
        issued_q <= 1'b1;
      end
      if (mul_done) begin
        issued_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            n_q  <= s_axis_tdata;
            st_q <= (s_axis_tdata == '0) ? ST_DONE : ST_QY;
          end
        end
        ST_QY: begin
          // dz from the old state, before any update of this step
          if (mul_start) dz_q <= sub_s(x_q, y_q);
          if (mul_done) begin
            qy_q <= mul_r;
            st_q <= ST_XY;
          end
        end
        ST_XY: begin
          if (mul_done) begin
            xy_q <= mul_r;
            st_q <= ST_XX;
          end
        end
        ST_XX: begin
          if (mul_done) begin
            xx_q <= mul_r;
            st_q <= ST_DX;
          end
        end
        ST_DX: begin
          if (mul_start) ty_q <= add_s(sub_s(sub_s('0, qy_q), xy_q), z_q);
          if (mul_done) begin
            dx_q <= mul_r;
            st_q <= ST_DY;
          end
        end
        ST_DY: begin
          if (mul_done) begin
            dy_q <= mul_r;
            st_q <= ST_UX;
          end
        end
        ST_UX: begin
          if (mul_done) begin
            x_q  <= add_s(x_q, mul_r);
            st_q <= ST_UY;
          end
        end
        ST_UY: begin
          if (mul_done) begin
            y_q  <= add_s(y_q, mul_r);
            st_q <= ST_UZ;
          end
        end
        ST_UZ: begin
          if (mul_done) begin
            z_q  <= add_s(z_q, mul_r);
            n_q  <= n_q - 1'b1;
            st_q <= (n_q == COUNT_BITS'(1)) ? ST_DONE : ST_QY;
          end
        end
        ST_DONE: begin
          // wait for the output register to free up
          if (out_load) begin
            out_data_q <= {to_out(z_q), to_out(y_q), to_out(x_q)};
            st_q       <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // the multiplier only finishes while a multiply state waits for it
  a_done_in_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (mul_state && issued_q))
    else $error("multiplier result outside a multiply state");

  // a nonzero step count starts the first step
  a_start_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tdata != '0)) |=> (st_q == ST_QY))
    else $error("step sequence did not start");

  // the step counter is never empty while steps run
  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_state) |-> (n_q != '0))
    else $error("step counter empty during a step");

  // a new word is only loaded once the previous one has gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending output word overwritten");

endmodule
